FILE: rtl/core/twhbl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the two-wire handshake byte link.
// Used by the link core and its port checker; no dependencies.
package twhbl_pkg;

  localparam int CounterWidth = 32;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_RECV = 2'd2;

  localparam logic [31:0] TimeoutReset = 32'd4000000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] tx_byte;
    logic       line_a_high;
    logic       line_b_high;
  } link_in_t;

  typedef struct packed {
    logic       pull_line_a;
    logic       pull_line_b;
    logic       busy_res;
    logic       byte_done;
    logic [7:0] rx_byte;
    logic       timed_out;
  } link_out_t;

endpackage

FILE: rtl/core/two_wire_handshake_byte_link.sv
`timescale 1ns / 1ps
// Two-wire open-drain byte link: handshake state machine and result register.
// Depends on twhbl_pkg for the beat types, op codes and counter width.
//
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one beat per clock:
//   a command (none, send, receive), the byte to send and the sampled levels
//   of lines A and B. Each accepted beat advances the handshake machine by
//   one step and produces exactly one result beat on the output channel
//   (out_valid/out_ready/out_data): which lines to pull low next, busy, the
//   byte-done and timeout pulses, and the received byte on completion.
//   A send shifts the byte out LSB first; a receive shifts bits in at the MSB.
//   Commands are honoured only while idle.
//   cfg_we/cfg_wdata write the receive timeout limit, counted in accepted
//   beats; write it only while the link is idle.
//   The result of a beat is registered and shown in the cycle after it is
//   accepted. Throughput: one beat per cycle when not stalled, set by the single
//   next-state step between the state registers and the result register.
//   Stall: while a result waits with out_ready low, in_ready drops and the
//   state holds; a new beat is taken in the same cycle the waiting result is.
//   Reset: the link returns to idle and no result is pending (the payload
//   register is not reset); the timeout limit returns to 4000000.
module two_wire_handshake_byte_link (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  twhbl_pkg::link_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output twhbl_pkg::link_out_t out_data,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);
  import twhbl_pkg::*;

  localparam int CmpWidth = (CounterWidth > 32) ? CounterWidth : 32;
  localparam logic [CounterWidth-1:0] CntMax = {CounterWidth{1'b1}};
  localparam logic [2:0] LastBit = 3'd7;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_TX_PULL = 6'b000010,
    PH_TX_REL  = 6'b000100,
    PH_RX_WAIT = 6'b001000,
    PH_RX_ACK1 = 6'b010000,
    PH_RX_ACK0 = 6'b100000
  } phase_t;

  phase_t                  phase, phase_next;
  logic [2:0]              bits_done, bits_done_next;
  logic [7:0]              shift_byte, shift_byte_next;
  logic [CounterWidth-1:0] elapsed, elapsed_next;
  logic [31:0]             timeout_limit;
  link_out_t               res;
  logic                    in_fire;
  logic                    waiting;
  logic                    tx_one;
  logic                    a_hi, b_hi;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign a_hi     = in_data.line_a_high;
  assign b_hi     = in_data.line_b_high;
  assign tx_one   = shift_byte[0];

  always_comb begin
    phase_next      = phase;
    bits_done_next  = bits_done;
    shift_byte_next = shift_byte;
    elapsed_next    = elapsed;
    waiting         = 1'b0;
    res             = '0;

    // receive steps count up, saturating
    if ((phase == PH_RX_WAIT || phase == PH_RX_ACK1 || phase == PH_RX_ACK0) &&
        elapsed != CntMax) begin
      elapsed_next = elapsed + 1'b1;
    end

    case (phase)
      PH_IDLE: begin
        if (in_data.op == OP_SEND) begin
          shift_byte_next = in_data.tx_byte;
          bits_done_next  = '0;
          phase_next      = PH_TX_PULL;
        end else if (in_data.op == OP_RECV) begin
          shift_byte_next = '0;
          bits_done_next  = '0;
          elapsed_next    = '0;
          phase_next      = PH_RX_WAIT;
        end
      end
      PH_TX_PULL: begin
        if (tx_one ? !a_hi : !b_hi) begin
          phase_next = PH_TX_REL;
        end
      end
      PH_TX_REL: begin
        if (tx_one ? a_hi : b_hi) begin
          shift_byte_next = {1'b0, shift_byte[7:1]};
          if (bits_done == LastBit) begin
            bits_done_next = '0;
            phase_next     = PH_IDLE;
            res.byte_done  = 1'b1;
          end else begin
            bits_done_next = bits_done + 1'b1;
            phase_next     = PH_TX_PULL;
          end
        end
      end
      PH_RX_WAIT: begin
        if (a_hi && b_hi) begin
          waiting = 1'b1;
        end else if (a_hi) begin
          shift_byte_next = {1'b1, shift_byte[7:1]};
          phase_next      = PH_RX_ACK1;
        end else begin
          shift_byte_next = {1'b0, shift_byte[7:1]};
          phase_next      = PH_RX_ACK0;
        end
      end
      PH_RX_ACK1, PH_RX_ACK0: begin
        if (phase == PH_RX_ACK1 ? b_hi : a_hi) begin
          if (bits_done == LastBit) begin
            bits_done_next = '0;
            phase_next     = PH_IDLE;
            res.byte_done  = 1'b1;
            res.rx_byte    = shift_byte;
          end else begin
            bits_done_next = bits_done + 1'b1;
            phase_next     = PH_RX_WAIT;
          end
        end else begin
          waiting = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // abort a stalled receive once the count passes the limit
    if (waiting && (CmpWidth'(elapsed_next) > CmpWidth'(timeout_limit))) begin
      phase_next     = PH_IDLE;
      bits_done_next = '0;
      res.timed_out  = 1'b1;
    end

    res.pull_line_a = (phase_next == PH_TX_PULL && !shift_byte_next[0]) ||
                      (phase_next == PH_RX_ACK1);
    res.pull_line_b = (phase_next == PH_TX_PULL && shift_byte_next[0]) ||
                      (phase_next == PH_RX_ACK0);
    res.busy_res    = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bits_done     <= '0;
      shift_byte    <= '0;
      elapsed       <= '0;
      out_valid     <= 1'b0;
      timeout_limit <= TimeoutReset;
    end else begin
      if (cfg_we) begin
        timeout_limit <= cfg_wdata;
      end
      if (in_fire) begin
        phase      <= phase_next;
        bits_done  <= bits_done_next;
        shift_byte <= shift_byte_next;
        elapsed    <= elapsed_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload: load on each accepted beat, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res;
    end
  end

endmodule

FILE: rtl/core/twhbl_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the two-wire handshake byte link, bound to the top.
// Depends on twhbl_pkg for the beat types.
module twhbl_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input twhbl_pkg::link_out_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_one_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.pull_line_a && out_data.pull_line_b))
    else $error("both lines pulled at once");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.byte_done || out_data.timed_out) |->
      !out_data.busy_res && !(out_data.byte_done && out_data.timed_out))
    else $error("byte end reported while still busy or twice");

  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.pull_line_a || out_data.pull_line_b) |-> out_data.busy_res)
    else $error("line pulled while idle");

  a_rx_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_done |-> out_data.rx_byte == 8'd0)
    else $error("received byte shown without byte done");

endmodule

bind two_wire_handshake_byte_link twhbl_checker u_twhbl_checker (.*);
